### rtl/apl_pkg.sv
// ----------------------------------------------------------------------------
// Peak level meter package
// Shared widths, constants, register indexes and types of the level meter.
// ----------------------------------------------------------------------------
package apl_pkg;

    // Default values of the top-level parameters.
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths.
    localparam int CHANNEL_W  = 3;
    localparam int TIMECODE_W = 63;
    localparam int LEVEL_W    = 13;
    localparam int HOLD_W     = 32;
    localparam int DECAY_W    = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME  = 1'b0,
        REG_DECAY_STEP = 1'b1
    } t_cfg_reg;

    // Configuration values after reset.
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 32'd100000000;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd16;

    // Level floor in sixteenths of a dB; it stands for silence.
    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -13'sd2560;

    // Fixed-point log conversion.
    localparam int FRAC_BITS = 16;                 // fraction bits of log2
    localparam int X_W       = 31;                 // Q1.30 mantissa in [1,2)
    localparam int E_W       = 5;                  // exponent, at most 30
    localparam int LG_W      = E_W + FRAC_BITS;    // log2 in Q16
    localparam int COEF_W    = 23;
    localparam logic [COEF_W-1:0] LOG_COEF = 23'd6313057;  // 320*log10(2) in Q16
    localparam int P_W       = LG_W + COEF_W;
    localparam int Q_W       = P_W + 1 - 32;
    localparam logic [Q_W-1:0] LEVEL_LIMIT = 13'd2560;

    // Channel and timecode that travel with a block result.
    typedef struct packed {
        logic [CHANNEL_W-1:0]  ch;
        logic [TIMECODE_W-1:0] tc;
    } t_tag;

endpackage

### rtl/apl_level_conv.sv
// ----------------------------------------------------------------------------
// Peak level converter
// Pipelined conversion of a block peak magnitude to a level in 1/16 dB:
// normalization, sixteen squaring steps for the log2 fraction, scaling.
// ----------------------------------------------------------------------------
module apl_level_conv
    import apl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [SAMPLE_BITS-2:0]    i_mag,
    input  t_tag                      i_tag,
    output logic                      o_valid,
    output t_tag                      o_tag,
    output logic signed [LEVEL_W-1:0] o_level
);

    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int NSTEPS = FRAC_BITS;
    localparam logic [LG_W-1:0] LG_BASE = LG_W'((SAMPLE_BITS - 1) << FRAC_BITS);
    localparam logic [P_W:0]    ROUND_UP = (P_W+1)'(64'hFFFF_FFFF);

    // Position of the highest set bit.
    function automatic logic [E_W-1:0] msb_index(input logic [MAG_W-1:0] v);
        logic [E_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                idx = E_W'(i);
            end
        end
        return idx;
    endfunction

    // Input stage.
    logic             r_in_v;
    logic [MAG_W-1:0] r_in_mag;
    t_tag             r_in_tag;

    // Squaring chain: entry 0 holds the normalized value.
    logic                 r_v    [NSTEPS+1];
    logic [X_W-1:0]       r_x    [NSTEPS+1];
    logic [FRAC_BITS-1:0] r_frac [NSTEPS+1];
    logic [E_W-1:0]       r_e    [NSTEPS+1];
    logic                 r_zero [NSTEPS+1];
    t_tag                 r_tag  [NSTEPS+1];

    // Scaling stage.
    logic           r_p_v;
    logic [P_W-1:0] r_p;
    logic           r_p_zero;
    t_tag           r_p_tag;

    // Output stage.
    logic                      r_o_v;
    logic signed [LEVEL_W-1:0] r_o_level;
    t_tag                      r_o_tag;

    // Normalization of the magnitude to Q1.30.
    logic [E_W-1:0] n_e;
    logic [E_W-1:0] n_sh;
    logic [X_W-1:0] n_x;

    always_comb begin
        n_e  = msb_index(r_in_mag);
        n_sh = E_W'(X_W - 1) - n_e;
        n_x  = X_W'(r_in_mag) << n_sh;
    end

    // Distance below full scale and its scaling to 1/16 dB.
    logic [LG_W-1:0] n_d;
    logic [P_W-1:0]  n_p;
    logic [P_W:0]    n_sum;
    logic [Q_W-1:0]  n_q;
    logic signed [LEVEL_W-1:0] n_level;

    always_comb begin
        n_d   = LG_BASE - {r_e[NSTEPS], r_frac[NSTEPS]};
        n_p   = P_W'(n_d) * P_W'(LOG_COEF);
        n_sum = {1'b0, r_p} + ROUND_UP;
        n_q   = n_sum[P_W:32];
        if (r_p_zero || (n_q > LEVEL_LIMIT)) begin
            n_level = LEVEL_FLOOR;
        end else begin
            n_level = $signed(LEVEL_W'(Q_W'(0) - n_q));
        end
    end

    // Valid bits of all stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_p_v  <= 1'b0;
            r_o_v  <= 1'b0;
            for (int k = 0; k <= NSTEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_in_v <= i_valid;
            r_v[0] <= r_in_v;
            for (int k = 0; k < NSTEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_p_v <= r_v[NSTEPS];
            r_o_v <= r_p_v;
        end
    end

    // Payload of the input, normalization, scaling and output stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_mag  <= i_mag;
            r_in_tag  <= i_tag;
            r_x[0]    <= n_x;
            r_frac[0] <= '0;
            r_e[0]    <= n_e;
            r_zero[0] <= (r_in_mag == '0);
            r_tag[0]  <= r_in_tag;
            r_p       <= n_p;
            r_p_zero  <= r_zero[NSTEPS];
            r_p_tag   <= r_tag[NSTEPS];
            r_o_level <= n_level;
            r_o_tag   <= r_p_tag;
        end
    end

    // One squaring step per stage; each gives one fraction bit of log2.
    for (genvar k = 0; k < NSTEPS; k++) begin : g_sq
        logic [2*X_W-1:0] sq;
        logic [X_W:0]     y;

        always_comb begin
            sq = r_x[k] * r_x[k];
            y  = sq[2*X_W-1:X_W-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= y[X_W] ? y[X_W:1] : y[X_W-1:0];
                r_frac[k+1] <= {r_frac[k][FRAC_BITS-2:0], y[X_W]};
                r_e[k+1]    <= r_e[k];
                r_zero[k+1] <= r_zero[k];
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_tag   = r_o_tag;
    assign o_level = r_o_level;

endmodule

### rtl/audio_peak_level_meter.sv
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while o_stall is low. The level converter
// is a pipeline with one multiplier per squaring step and one for scaling, and
// channel state is updated once per cycle.
// Reset (synchronous, active low) restores the default hold time and decay
// step, clears all block maxima and sets display and held peak to the floor.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Audio peak level meter
// Per-channel peak meter with decaying display level and timed peak hold.
// ----------------------------------------------------------------------------
module audio_peak_level_meter
    import apl_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // Sample channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [CHANNEL_W-1:0]         i_channel,
    input  logic                         i_block_end,
    input  logic [TIMECODE_W-1:0]        i_timecode,
    // Result channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [CHANNEL_W-1:0]         o_out_channel,
    output logic signed [LEVEL_W-1:0]    o_display_level,
    output logic signed [LEVEL_W-1:0]    o_held_peak
);

    localparam int MAG_W    = SAMPLE_BITS - 1;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers.
    logic [HOLD_W-1:0]  r_hold;
    logic [DECAY_W-1:0] r_decay;

    // Per-channel state.
    logic [MAG_W-1:0]          r_bmax  [CHANNELS];
    logic signed [LEVEL_W-1:0] r_disp  [CHANNELS];
    logic signed [LEVEL_W-1:0] r_peak  [CHANNELS];
    logic [TIMECODE_W-1:0]     r_stamp [CHANNELS];

    // Output register.
    logic                      r_out_valid;
    logic [CHANNEL_W-1:0]      r_out_ch;
    logic signed [LEVEL_W-1:0] r_out_disp;
    logic signed [LEVEL_W-1:0] r_out_peak;

    // The whole pipeline moves when the output register is free or drained.
    logic adv;
    logic acc;

    assign adv = !r_out_valid || !i_stall;
    assign acc = i_valid && adv;

    // Sample magnitude with the most negative value saturated.
    logic                ch_ok;
    logic [CH_IDX_W-1:0] in_idx;
    logic [SAMPLE_BITS-1:0] neg;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    n_max;
    logic                conv_in_v;
    t_tag                conv_in_tag;

    always_comb begin
        ch_ok  = (32'(i_channel) < CHANNELS);
        in_idx = CH_IDX_W'(i_channel);
        neg    = SAMPLE_BITS'(0) - i_sample;
        if (i_sample == {1'b1, {MAG_W{1'b0}}}) begin
            mag = '1;
        end else if (i_sample[SAMPLE_BITS-1]) begin
            mag = neg[MAG_W-1:0];
        end else begin
            mag = i_sample[MAG_W-1:0];
        end
        n_max          = (mag > r_bmax[in_idx]) ? mag : r_bmax[in_idx];
        conv_in_v      = acc && ch_ok && i_block_end;
        conv_in_tag.ch = i_channel;
        conv_in_tag.tc = i_timecode;
    end

    // Level conversion pipeline.
    logic                      conv_v;
    t_tag                      conv_tag;
    logic signed [LEVEL_W-1:0] conv_level;

    apl_level_conv #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (conv_in_v),
        .i_mag   (n_max),
        .i_tag   (conv_in_tag),
        .o_valid (conv_v),
        .o_tag   (conv_tag),
        .o_level (conv_level)
    );

    // Display decay and peak hold update for the converted channel.
    logic [CH_IDX_W-1:0]       out_idx;
    logic signed [LEVEL_W:0]   disp_dec;
    logic signed [LEVEL_W:0]   lvl_ext;
    logic signed [LEVEL_W-1:0] n_disp;
    logic [TIMECODE_W-1:0]     age;
    logic                      expired;
    logic signed [LEVEL_W-1:0] pk_base;
    logic                      raise;
    logic signed [LEVEL_W-1:0] n_peak;

    always_comb begin
        out_idx  = CH_IDX_W'(conv_tag.ch);
        disp_dec = $signed({r_disp[out_idx][LEVEL_W-1], r_disp[out_idx]}
                           - (LEVEL_W+1)'(r_decay));
        lvl_ext  = {conv_level[LEVEL_W-1], conv_level};
        // The new level never lies below the floor, so neither does the maximum.
        n_disp   = (lvl_ext > disp_dec) ? conv_level : LEVEL_W'(disp_dec);
        age      = conv_tag.tc - r_stamp[out_idx];
        expired  = (conv_tag.tc >= r_stamp[out_idx]) && (age > TIMECODE_W'(r_hold));
        pk_base  = expired ? LEVEL_FLOOR : r_peak[out_idx];
        raise    = conv_level > pk_base;
        n_peak   = raise ? conv_level : pk_base;
    end

    // Configuration, channel state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= HOLD_RESET;
            r_decay     <= DECAY_RESET;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_bmax[c]  <= '0;
                r_disp[c]  <= LEVEL_FLOOR;
                r_peak[c]  <= LEVEL_FLOOR;
                r_stamp[c] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_HOLD_TIME: begin
                        r_hold <= i_cfg_data[HOLD_W-1:0];
                    end
                    REG_DECAY_STEP: begin
                        r_decay <= i_cfg_data[DECAY_W-1:0];
                    end
                endcase
            end
            if (acc && ch_ok) begin
                r_bmax[in_idx] <= i_block_end ? '0 : n_max;
            end
            if (adv) begin
                r_out_valid <= conv_v;
                if (conv_v) begin
                    r_disp[out_idx] <= n_disp;
                    r_peak[out_idx] <= n_peak;
                    if (raise) begin
                        r_stamp[out_idx] <= conv_tag.tc;
                    end
                end
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (adv && conv_v) begin
            r_out_ch   <= conv_tag.ch;
            r_out_disp <= n_disp;
            r_out_peak <= n_peak;
        end
    end

    assign o_stall         = !adv;
    assign o_valid         = r_out_valid;
    assign o_out_channel   = r_out_ch;
    assign o_display_level = r_out_disp;
    assign o_held_peak     = r_out_peak;

endmodule
